// ----- rtl/indexed_list_engine_assert.svh -----
// assertion macros for the indexed list engine
`ifndef INDEXED_LIST_ENGINE_ASSERT_SVH
`define INDEXED_LIST_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define ILE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define ILE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ILE_ASSERT_IMP(lbl, ante, cons, msg)
`define ILE_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/ile_pkg.sv -----
`default_nettype none

package ile_pkg;

  localparam int unsigned POS_W          = 7;
  localparam int unsigned DATA_IN_W      = 32;
  localparam int unsigned COUNT_W        = 7;
  localparam int unsigned CAPACITY_DEF   = 64;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_GET    = 2'd2,
    ACT_SET    = 2'd3
  } action_e;

  // command broadcast to every cell
  typedef struct packed {
    logic             en;
    action_e          action;
    logic [POS_W-1:0] pos;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/ile_if.sv -----
`default_nettype none

interface ile_req_if;
  logic                           valid;
  logic                           ready;
  ile_pkg::action_e               action;
  logic [ile_pkg::POS_W-1:0]      position;
  logic [ile_pkg::DATA_IN_W-1:0]  data_in;

  modport source (output valid, action, position, data_in, input ready);
  modport sink (input valid, action, position, data_in, output ready);
endinterface

interface ile_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           ok;
  logic [ile_pkg::DATA_IN_W-1:0]  data_out;
  logic [ile_pkg::COUNT_W-1:0]    count;

  modport source (output valid, ok, data_out, count, input ready);
  modport sink (input valid, ok, data_out, count, output ready);
endinterface

`default_nettype wire

// ----- rtl/ile_cell.sv -----
`default_nettype none

module ile_cell #(
  parameter int unsigned CAPACITY   = ile_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = ile_pkg::DATA_WIDTH_DEF,
  parameter int unsigned INDEX      = 0
) (
  input  wire                  clk_i,
  input  wire ile_pkg::cmd_t   cmd_i,
  input  wire [DATA_WIDTH-1:0] new_word_i,
  input  wire [DATA_WIDTH-1:0] left_word_i,
  input  wire [DATA_WIDTH-1:0] right_word_i,
  output logic [DATA_WIDTH-1:0] word_o,
  output logic [DATA_WIDTH-1:0] rd_o
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CMP_W = (IDX_W > ile_pkg::POS_W) ? IDX_W : ile_pkg::POS_W;
  localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

  logic [DATA_WIDTH-1:0] word_q, word_d;
  logic [CMP_W-1:0]      pos_c;
  logic                  hit, after;

  assign pos_c = CMP_W'(cmd_i.pos);
  assign hit   = (pos_c == IDX);
  assign after = (IDX > pos_c);

  always_comb begin
    word_d = word_q;
    if (cmd_i.en) begin
      case (cmd_i.action)
        ile_pkg::ACT_INSERT: begin
          if (hit) begin
            word_d = new_word_i;
          end else if (after) begin
            word_d = left_word_i;
          end
        end
        ile_pkg::ACT_REMOVE: begin
          if (hit || after) begin
            word_d = right_word_i;
          end
        end
        ile_pkg::ACT_SET: begin
          if (hit) begin
            word_d = new_word_i;
          end
        end
        default: begin
          word_d = word_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;
  assign rd_o   = (cmd_i.en && (cmd_i.action == ile_pkg::ACT_GET) && hit) ? word_q : '0;

endmodule

`default_nettype wire

// ----- rtl/indexed_list_engine.sv -----
`default_nettype none

// Bounded positional list held in a row of CAPACITY word cells. Each request
// (insert, remove, get or set at a list position) is taken by all cells:
// every cell decides from the broadcast command whether to keep its word,
// load the new word or take its left or right neighbour's word, so an insert
// or remove shifts all later entries as the request is taken. The result sits
// in an output register and is offered in the cycle after the request is taken;
// a new request is taken in every cycle in which the result side takes the
// previous one, giving one item per cycle. Out-of-range positions and inserts
// into a full list come back with ok low, count unchanged and data_out zero.

`include "indexed_list_engine_assert.svh"

module indexed_list_engine #(
  parameter int unsigned CAPACITY   = ile_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = ile_pkg::DATA_WIDTH_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  ile_req_if.sink    req_i,
  ile_rsp_if.source  rsp_o
);

  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W     = (CNT_W > ile_pkg::POS_W) ? CNT_W : ile_pkg::POS_W;
  localparam int unsigned OUT_CNT_W = ile_pkg::COUNT_W;
  localparam int unsigned OUT_DAT_W = ile_pkg::DATA_IN_W;

  logic [CNT_W-1:0]      count_q, count_d;
  logic                  rsp_valid_q, rsp_valid_d;
  logic                  rsp_ok_q;
  logic [OUT_DAT_W-1:0]  rsp_data_q;
  logic [OUT_CNT_W-1:0]  rsp_count_q;

  logic                  accept;
  logic                  ok_c;
  logic [CMP_W-1:0]      pos_w, cnt_w, cap_w;
  logic [DATA_WIDTH-1:0] new_word;
  logic [DATA_WIDTH-1:0] rd_any;
  ile_pkg::cmd_t         cmd;

  logic [DATA_WIDTH-1:0] word_w [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_w   [CAPACITY];

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign pos_w    = CMP_W'(req_i.position);
  assign cnt_w    = CMP_W'(count_q);
  assign cap_w    = CMP_W'(CAPACITY);
  assign new_word = DATA_WIDTH'(req_i.data_in);

  always_comb begin
    case (req_i.action)
      ile_pkg::ACT_INSERT: ok_c = (pos_w <= cnt_w) && (cnt_w < cap_w);
      ile_pkg::ACT_REMOVE: ok_c = (pos_w < cnt_w);
      ile_pkg::ACT_GET:    ok_c = (pos_w < cnt_w);
      ile_pkg::ACT_SET:    ok_c = (pos_w < cnt_w);
      default:             ok_c = 1'b0;
    endcase
  end

  assign cmd.en     = accept && ok_c;
  assign cmd.action = req_i.action;
  assign cmd.pos    = req_i.position;

  always_comb begin
    count_d = count_q;
    if (cmd.en && (req_i.action == ile_pkg::ACT_INSERT)) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd.en && (req_i.action == ile_pkg::ACT_REMOVE)) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = word_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = word_w[i+1];
    end

    ile_cell #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH),
      .INDEX      (i)
    ) u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .new_word_i   (new_word),
      .left_word_i  (left_w),
      .right_word_i (right_w),
      .word_o       (word_w[i]),
      .rd_o         (rd_w[i])
    );
  end

  always_comb begin
    rd_any = '0;
    for (int unsigned k = 0; k < CAPACITY; k++) begin
      rd_any = rd_any | rd_w[k];
    end
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (accept) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_ok_q    <= ok_c;
      rsp_data_q  <= OUT_DAT_W'(rd_any);
      rsp_count_q <= OUT_CNT_W'(count_d);
    end
  end

  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.ok       = rsp_ok_q;
  assign rsp_o.data_out = rsp_data_q;
  assign rsp_o.count    = rsp_count_q;

  `ILE_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY), "list count above capacity")
  `ILE_ASSERT_NXT(a_refused_holds, accept && !ok_c, count_q == $past(count_q), "refused item changed count")
  `ILE_ASSERT_NXT(a_rsp_count, accept, rsp_valid_q && (rsp_count_q == OUT_CNT_W'(count_q)), "result count differs from list count")
  `ILE_ASSERT_IMP(a_refused_zero, rsp_valid_q && !rsp_ok_q, rsp_data_q == '0, "refused item returned data")

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CAPACITY    = ile_pkg::CAPACITY_DEF;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct {
    logic                          ok;
    logic [ile_pkg::DATA_IN_W-1:0] word;
    logic [ile_pkg::COUNT_W-1:0]   count;
  } list_result_t;

  class list_tracker;
    logic [ile_pkg::DATA_IN_W-1:0] words [CAPACITY];
    int unsigned                   held;
    list_result_t                  awaited_results [$];
    int unsigned                   failures;

    function new();
      held     = 0;
      failures = 0;
      foreach (words[i]) words[i] = '0;
    endfunction

    function void note_request(ile_pkg::action_e act, logic [ile_pkg::POS_W-1:0] pos,
                               logic [ile_pkg::DATA_IN_W-1:0] word);
      list_result_t res;
      int           p;
      p         = int'(pos);
      res.ok    = 1'b0;
      res.word  = '0;
      case (act)
        ile_pkg::ACT_INSERT: begin
          if (p <= int'(held) && held < CAPACITY) begin
            for (int i = int'(held); i > p; i--) words[i] = words[i-1];
            words[p] = word;
            held++;
            res.ok = 1'b1;
          end
        end
        ile_pkg::ACT_REMOVE: begin
          if (p < int'(held)) begin
            for (int i = p; i + 1 < int'(held); i++) words[i] = words[i+1];
            held--;
            res.ok = 1'b1;
          end
        end
        ile_pkg::ACT_GET: begin
          if (p < int'(held)) begin
            res.word = words[p];
            res.ok   = 1'b1;
          end
        end
        default: begin
          if (p < int'(held)) begin
            words[p] = word;
            res.ok   = 1'b1;
          end
        end
      endcase
      res.count = held[ile_pkg::COUNT_W-1:0];
      awaited_results.push_back(res);
    endfunction

    function void check_result(logic ok, logic [ile_pkg::DATA_IN_W-1:0] word,
                               logic [ile_pkg::COUNT_W-1:0] count);
      list_result_t want;
      if (awaited_results.size() == 0) begin
        if (failures < MAX_REPORTS)
          $display("unexpected result: ok=%0b data=%h count=%0d", ok, word, count);
        failures++;
      end else begin
        want = awaited_results.pop_front();
        if (ok !== want.ok || word !== want.word || count !== want.count) begin
          if (failures < MAX_REPORTS)
            $display("mismatch: expected ok=%0b data=%h count=%0d, got ok=%0b data=%h count=%0d",
                     want.ok, want.word, want.count, ok, word, count);
          failures++;
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned send_idle_pct = 19;
  int unsigned recv_idle_pct = 79;
  int unsigned stalled_cycles = 0;
  int unsigned list_len = 0;
  bit          filling = 1'b1;
  list_tracker shadow_list = new();

  ile_req_if req_bus ();
  ile_rsp_if rsp_bus ();

  indexed_list_engine dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    req_bus.valid    = 1'b0;
    req_bus.action   = ile_pkg::ACT_GET;
    req_bus.position = '0;
    req_bus.data_in  = '0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // accepted items feed the shadow list, results are checked against it
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_bus.valid && req_bus.ready)
        shadow_list.note_request(req_bus.action, req_bus.position, req_bus.data_in);
      if (rsp_bus.valid && rsp_bus.ready)
        shadow_list.check_result(rsp_bus.ok, rsp_bus.data_out, rsp_bus.count);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_request(input ile_pkg::action_e act,
                              input logic [ile_pkg::POS_W-1:0] pos,
                              input logic [ile_pkg::DATA_IN_W-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid    <= 1'b1;
    req_bus.action   <= act;
    req_bus.position <= pos;
    req_bus.data_in  <= word;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    // track the length to aim positions
    if (act == ile_pkg::ACT_INSERT && int'(pos) <= int'(list_len) && list_len < CAPACITY)
      list_len++;
    else if (act == ile_pkg::ACT_REMOVE && int'(pos) < int'(list_len))
      list_len--;
  endtask

  task automatic run_directed();
    send_request(ile_pkg::ACT_GET, 7'd0, 32'd0);
    send_request(ile_pkg::ACT_REMOVE, 7'd0, 32'd0);
    send_request(ile_pkg::ACT_SET, 7'd0, 32'h1234_5678);
    send_request(ile_pkg::ACT_INSERT, 7'd1, 32'hDEAD_BEEF);
    send_request(ile_pkg::ACT_INSERT, 7'd0, 32'hFFFF_FFFF);
    send_request(ile_pkg::ACT_INSERT, 7'd0, 32'h0000_0000);
    send_request(ile_pkg::ACT_INSERT, 7'd2, 32'hA5A5_A5A5);
    send_request(ile_pkg::ACT_INSERT, 7'd1, 32'h5A5A_5A5A);
    send_request(ile_pkg::ACT_GET, 7'd0, 32'hFFFF_FFFF);
    send_request(ile_pkg::ACT_GET, 7'd1, 32'd0);
    send_request(ile_pkg::ACT_GET, 7'd2, 32'd0);
    send_request(ile_pkg::ACT_GET, 7'd3, 32'd0);
    send_request(ile_pkg::ACT_SET, 7'd3, 32'h0000_0001);
    send_request(ile_pkg::ACT_GET, 7'd3, 32'd0);
    send_request(ile_pkg::ACT_REMOVE, 7'd1, 32'd0);
    send_request(ile_pkg::ACT_GET, 7'd127, 32'd0);
    send_request(ile_pkg::ACT_REMOVE, 7'd3, 32'd0);
    send_request(ile_pkg::ACT_INSERT, 7'd64, 32'h8000_0000);
    send_request(ile_pkg::ACT_SET, 7'd100, 32'hFFFF_FFFF);
    send_request(ile_pkg::ACT_REMOVE, 7'd0, 32'd0);
    send_request(ile_pkg::ACT_REMOVE, 7'd1, 32'd0);
    send_request(ile_pkg::ACT_GET, 7'd0, 32'd0);
  endtask

  task automatic run_random(input int unsigned n_items);
    ile_pkg::action_e              act;
    logic [ile_pkg::POS_W-1:0]     pos;
    logic [ile_pkg::DATA_IN_W-1:0] word;
    int unsigned                   roll;
    repeat (n_items) begin
      // sweep the list between empty and full, lingering at full now and then
      if (list_len == CAPACITY && $urandom_range(3) == 0) filling = 1'b0;
      else if (list_len == 0) filling = 1'b1;
      else if ($urandom_range(39) == 0) filling = !filling;
      roll = $urandom_range(99);
      if (roll < (filling ? 55 : 15)) act = ile_pkg::ACT_INSERT;
      else if (roll < 70) act = ile_pkg::ACT_REMOVE;
      else if (roll < 85) act = ile_pkg::ACT_GET;
      else act = ile_pkg::ACT_SET;
      if ($urandom_range(99) < 15) pos = ile_pkg::POS_W'($urandom_range(127));
      else if (act == ile_pkg::ACT_INSERT) pos = ile_pkg::POS_W'($urandom_range(list_len));
      else if (list_len == 0) pos = '0;
      else pos = ile_pkg::POS_W'($urandom_range(list_len - 1));
      roll = $urandom_range(9);
      if (roll == 0) word = '0;
      else if (roll == 1) word = '1;
      else word = $urandom;
      send_request(act, pos, word);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random(600);
    send_idle_pct = 79;
    recv_idle_pct = 19;
    run_random(600);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(600);
    req_bus.valid <= 1'b0;
    while (shadow_list.awaited_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (shadow_list.failures == 0 && shadow_list.awaited_results.size() == 0)
      $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
